// ----- src/debounced_button_pwm_duty_stepper_assert.svh -----
// Assertion macros used by the duty stepper RTL (dbps_stepper).
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef DEBOUNCED_BUTTON_PWM_DUTY_STEPPER_ASSERT_SVH
`define DEBOUNCED_BUTTON_PWM_DUTY_STEPPER_ASSERT_SVH
`ifndef SYNTH
`define DBPS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dbps assertion failed");
`define DBPS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbps assertion failed");
`define DBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbps assertion failed");
`else
`define DBPS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DBPS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/dbps_pkg.sv -----
// Types, register indexes and reset constants of the PWM duty stepper.
// No dependencies.
package dbps_pkg;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PWM_PERIOD     = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DUTY_STEP      = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_STEPS      = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_TICKS = 8'd3;

    localparam logic [15:0] RST_PWM_PERIOD     = 16'd1000;
    localparam logic [15:0] RST_DUTY_STEP      = 16'd100;
    localparam logic [7:0]  RST_MAX_STEPS      = 8'd10;
    localparam logic [15:0] RST_DEBOUNCE_TICKS = 16'd50000;
    localparam logic [15:0] RST_DUTY_COMPARE   = 16'd500;
    localparam logic [7:0]  RST_STEP_COUNT     = 8'd5;
    localparam logic [15:0] DUTY_MAX           = 16'hFFFF;

    localparam logic [1:0] PHASE_CODE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_CODE_PRESS   = 2'd1;
    localparam logic [1:0] PHASE_CODE_HELD    = 2'd2;
    localparam logic [1:0] PHASE_CODE_RELEASE = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PRESS   = 4'b0010,
        PH_HELD    = 4'b0100,
        PH_RELEASE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [15:0] duty_step;
        logic [7:0]  max_steps;
        logic [15:0] debounce_ticks;
    } step_cfg_t;

    typedef struct packed {
        logic [15:0] duty;
        logic [7:0]  steps;
        logic [1:0]  phase;
    } step_view_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_IDLE:    code = PHASE_CODE_IDLE;
            PH_PRESS:   code = PHASE_CODE_PRESS;
            PH_HELD:    code = PHASE_CODE_HELD;
            PH_RELEASE: code = PHASE_CODE_RELEASE;
            default:    code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- src/dbps_if.sv -----
// Valid/ready channel interfaces of the PWM duty stepper.
// Depends on dbps_pkg for the configuration port widths.
interface dbps_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface dbps_out_if;
    logic        valid;
    logic        ready;
    logic        pwm_out;
    logic        led_on;
    logic [15:0] duty_level;
    logic [7:0]  press_steps;
    logic [1:0]  debounce_phase;

    modport source (output valid, output pwm_out, output led_on, output duty_level,
                    output press_steps, output debounce_phase, input ready);
    modport sink (input valid, input pwm_out, input led_on, input duty_level,
                  input press_steps, input debounce_phase, output ready);
endinterface

interface dbps_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dbps_pkg::CFG_INDEX_BITS-1:0] index;
    logic [dbps_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/debounced_button_pwm_duty_stepper.sv -----
// Top level of the PWM generator with a debounced duty step button.
// Depends on dbps_pkg, dbps_if and dbps_stepper.
//
// Every input beat is one timer tick carrying the active-low button level, and it
// yields exactly one result beat: the PWM level, the LED level, and the duty compare,
// step count and debounce phase after that tick. A beat is taken in every clock cycle
// while the result register is empty or being drained; the tick's work is one pass of
// compare and increment logic from the state registers into the result register, so
// the result appears in the cycle after its input beat. Configuration writes are taken
// at any time, one per cycle.
module debounced_button_pwm_duty_stepper #(
    parameter int COUNTER_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    dbps_in_if.sink        button,
    dbps_out_if.source     result,
    dbps_cfg_if.sink       cfg
);

    localparam int CMP_BITS = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

    logic [15:0] pwm_period_reg;
    logic [15:0] duty_step_reg;
    logic [7:0]  max_steps_reg;
    logic [15:0] debounce_ticks_reg;

    logic [COUNTER_BITS-1:0] counter_reg, counter_next;
    logic [CMP_BITS-1:0]     counter_ext, period_ext, duty_ext;

    logic                  accept;
    logic                  pwm_level;
    dbps_pkg::step_cfg_t   step_cfg;
    dbps_pkg::step_view_t  view;

    logic        res_valid_reg;
    logic        res_pwm_reg;
    logic        res_led_reg;
    logic [15:0] res_duty_reg;
    logic [7:0]  res_steps_reg;
    logic [1:0]  res_phase_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg     <= dbps_pkg::RST_PWM_PERIOD;
            duty_step_reg      <= dbps_pkg::RST_DUTY_STEP;
            max_steps_reg      <= dbps_pkg::RST_MAX_STEPS;
            debounce_ticks_reg <= dbps_pkg::RST_DEBOUNCE_TICKS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dbps_pkg::CFG_PWM_PERIOD:     pwm_period_reg     <= cfg.data;
                dbps_pkg::CFG_DUTY_STEP:      duty_step_reg      <= cfg.data;
                dbps_pkg::CFG_MAX_STEPS:      max_steps_reg      <= cfg.data[7:0];
                dbps_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign accept = button.valid && button.ready;
    assign button.ready = !res_valid_reg || result.ready;

    assign step_cfg.duty_step      = duty_step_reg;
    assign step_cfg.max_steps      = max_steps_reg;
    assign step_cfg.debounce_ticks = debounce_ticks_reg;

    dbps_stepper u_stepper (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (accept),
        .btn     (button.button_level),
        .cfg     (step_cfg),
        .view    (view)
    );

    assign counter_ext = CMP_BITS'(counter_reg);
    assign period_ext  = CMP_BITS'(pwm_period_reg);
    assign duty_ext    = CMP_BITS'(view.duty);

    // A compare at or above the period (a zero period included) holds the output high.
    assign pwm_level = (duty_ext >= period_ext) || (counter_ext < duty_ext);

    always_comb
    begin
        if (counter_ext >= period_ext)
        begin
            counter_next = '0;
        end
        else
        begin
            counter_next = counter_reg + COUNTER_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                counter_reg <= counter_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_pwm_reg   <= pwm_level;
            res_led_reg   <= !button.button_level;
            res_duty_reg  <= view.duty;
            res_steps_reg <= view.steps;
            res_phase_reg <= view.phase;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.pwm_out        = res_pwm_reg;
    assign result.led_on         = res_led_reg;
    assign result.duty_level     = res_duty_reg;
    assign result.press_steps    = res_steps_reg;
    assign result.debounce_phase = res_phase_reg;

endmodule

// ----- src/dbps_stepper.sv -----
// Button debounce sequencer and duty compare stepper.
// Depends on dbps_pkg and the assertion macro header.
`include "debounced_button_pwm_duty_stepper_assert.svh"

module dbps_stepper (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic                btn,
    input  dbps_pkg::step_cfg_t cfg,
    output dbps_pkg::step_view_t view
);

    dbps_pkg::phase_t phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    logic [15:0] duty_reg, duty_next;
    logic [7:0]  steps_reg, steps_next;
    logic        last_reg;
    logic [16:0] duty_sum;
    logic        timer_done;

    assign duty_sum   = {1'b0, duty_reg} + {1'b0, cfg.duty_step};
    // A timer of zero ends the interval just like a timer of one.
    assign timer_done = (timer_reg <= 16'd1);

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        duty_next  = duty_reg;
        steps_next = steps_reg;
        case (phase_reg)
            dbps_pkg::PH_IDLE:
            begin
                if (last_reg && !btn)
                begin
                    timer_next = cfg.debounce_ticks;
                    phase_next = dbps_pkg::PH_PRESS;
                end
            end
            dbps_pkg::PH_PRESS:
            begin
                if (timer_done)
                begin
                    timer_next = 16'd0;
                    phase_next = dbps_pkg::PH_HELD;
                    if (steps_reg < cfg.max_steps)
                    begin
                        steps_next = steps_reg + 8'd1;
                        duty_next  = duty_sum[16] ? dbps_pkg::DUTY_MAX : duty_sum[15:0];
                    end
                    else
                    begin
                        steps_next = 8'd0;
                        duty_next  = 16'd0;
                    end
                end
                else
                begin
                    timer_next = timer_reg - 16'd1;
                end
            end
            dbps_pkg::PH_HELD:
            begin
                if (!last_reg && btn)
                begin
                    timer_next = cfg.debounce_ticks;
                    phase_next = dbps_pkg::PH_RELEASE;
                end
            end
            dbps_pkg::PH_RELEASE:
            begin
                if (timer_done)
                begin
                    timer_next = 16'd0;
                    phase_next = dbps_pkg::PH_IDLE;
                end
                else
                begin
                    timer_next = timer_reg - 16'd1;
                end
            end
            default:
            begin
                phase_next = dbps_pkg::PH_IDLE;
                timer_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dbps_pkg::PH_IDLE;
            timer_reg <= 16'd0;
            duty_reg  <= dbps_pkg::RST_DUTY_COMPARE;
            steps_reg <= dbps_pkg::RST_STEP_COUNT;
            last_reg  <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            duty_reg  <= duty_next;
            steps_reg <= steps_next;
            last_reg  <= btn;
        end
    end

    // The result of a beat shows the state after that beat's update.
    assign view.duty  = duty_next;
    assign view.steps = steps_next;
    assign view.phase = dbps_pkg::phase_code(phase_next);

    `DBPS_ASSERT_ALWAYS(a_phase_onehot, clk, rst_n, $onehot(phase_reg))
    `DBPS_ASSERT_IMPLIES(a_timer_idle_zero, clk, rst_n, (phase_reg == dbps_pkg::PH_IDLE || phase_reg == dbps_pkg::PH_HELD), (timer_reg == 16'd0))
    `DBPS_ASSERT_NEXT(a_hold_without_beat, clk, rst_n, !step_en, ($stable(duty_reg) && $stable(steps_reg) && $stable(phase_reg)))
    `DBPS_ASSERT_NEXT(a_press_expiry, clk, rst_n, (step_en && phase_reg == dbps_pkg::PH_PRESS && timer_done), (phase_reg == dbps_pkg::PH_HELD))

endmodule
